>>> hw/rtl/dwhm_pkg.sv
`timescale 1ns / 1ps

package dwhm_pkg;

  localparam int MAX_NAME_LEN  = 256;
  localparam int MAX_LABEL_LEN = 128;
  localparam int NAME_AW       = $clog2(MAX_NAME_LEN);
  localparam int LEN_W         = NAME_AW + 1;
  localparam int LBL_W         = $clog2(MAX_LABEL_LEN) + 1;

  typedef logic [7:0] byte_t;

  localparam logic  OP_HOST = 1'b0;
  localparam logic  OP_CERT = 1'b1;

  localparam byte_t CH_NUL  = 8'h00;
  localparam byte_t CH_DOT  = 8'h2e;
  localparam byte_t CH_STAR = 8'h2a;
  localparam byte_t CH_UP_A = 8'h41;
  localparam byte_t CH_UP_Z = 8'h5a;
  localparam byte_t CASE_OFS = 8'h20;

  function automatic byte_t to_lower(input byte_t ch);
    byte_t r;
    r = ch;
    if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
      r = ch + CASE_OFS;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/dwhm_ram.sv
`timescale 1ns / 1ps

module dwhm_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [dwhm_pkg::NAME_AW-1:0] waddr,
  input  dwhm_pkg::byte_t              wdata,
  input  logic [dwhm_pkg::NAME_AW-1:0] raddr,
  output dwhm_pkg::byte_t              rdata
);
  import dwhm_pkg::*;

  byte_t mem [MAX_NAME_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/dns_wildcard_host_match_top.sv
`timescale 1ns / 1ps
// channel   signals                                       beat
// in        in_valid in_ready opcode has_char char_value last   one name byte
// out       out_valid out_ready match too_long            one compare result
//
// load: one input beat per cycle while in_ready is high, host bytes then certificate bytes
// compare: starts after the last certificate beat unless a name overflowed; one
//   registered read port per store; a label scan waits on a store read for each
//   byte, as do a byte-run compare and an asterisk search; a wildcard search
//   re-reads host bytes, about segment length times host label length
// reset: control only, the name stores need no clearing
// stalls: the result sits in an output register; loading of the next name pair
//   goes on while it waits, the next result waits for it to be taken
module dns_wildcard_host_match_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            opcode,
  input  logic            has_char,
  input  dwhm_pkg::byte_t char_value,
  input  logic            last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            match,
  output logic            too_long
);
  import dwhm_pkg::*;

  // sequencer states
  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_WAIT     = 5'd1;
  localparam logic [4:0] S_PRE0     = 5'd2;
  localparam logic [4:0] S_PRE1     = 5'd3;
  localparam logic [4:0] S_PRE2     = 5'd4;
  localparam logic [4:0] S_EXACT    = 5'd5;
  localparam logic [4:0] S_EXACT_R  = 5'd6;
  localparam logic [4:0] S_LBL      = 5'd7;
  localparam logic [4:0] S_LBL_C    = 5'd8;
  localparam logic [4:0] S_LBL_M    = 5'd9;
  localparam logic [4:0] S_LM_TOP   = 5'd10;
  localparam logic [4:0] S_LM_BR    = 5'd11;
  localparam logic [4:0] S_LM_FINAL = 5'd12;
  localparam logic [4:0] S_LM_LIT   = 5'd13;
  localparam logic [4:0] S_LM_WILD  = 5'd14;
  localparam logic [4:0] S_FS_TRY   = 5'd15;
  localparam logic [4:0] S_FS_CHK   = 5'd16;
  localparam logic [4:0] S_LM_END   = 5'd17;
  localparam logic [4:0] S_SM_START = 5'd18;
  localparam logic [4:0] S_SM_USE   = 5'd19;
  localparam logic [4:0] S_NL_START = 5'd20;
  localparam logic [4:0] S_NL_DOT   = 5'd21;
  localparam logic [4:0] S_NL_SCAN  = 5'd22;
  localparam logic [4:0] S_NL_RET   = 5'd23;
  localparam logic [4:0] S_FS_START = 5'd24;
  localparam logic [4:0] S_FS_USE   = 5'd25;
  localparam logic [4:0] S_FIN      = 5'd26;

  logic [4:0] state, wait_ret, sub_ret;

  // load side
  logic [LEN_W-1:0] host_len, cert_len;
  logic             overflow_seen, host_closed;
  logic             in_fire, host_we, cert_we, host_room, cert_room, ovf_now;
  byte_t            cert_byte;

  // store read ports
  logic [NAME_AW-1:0] haddr, caddr;
  byte_t              hq, cq;

  // name walk: remaining, position, label start and length per name
  logic [LEN_W-1:0] hn, cn, hp, cp, hs, cs;
  logic [LBL_W-1:0] hl, cl;
  logic             fh, fc;

  // label compare
  logic [LBL_W-1:0] hi, ci, star, wpos, nxt, seg, fi, fs_i;
  logic [LBL_W-1:0] ci_inc;

  // byte-run compare
  logic [LEN_W-1:0] sh, sc, sn, sk;
  logic             sres;

  // label finder
  logic             nl_sel, nl_got;
  logic [LEN_W-1:0] nl_p, nl_r, nl_s, nl_p1, nl_r1;
  logic [LBL_W-1:0] nl_n;
  byte_t            nl_q;

  logic [LEN_W-1:0] hn_nul, cn_nul;
  logic             res_match, res_long;

  assign in_ready  = (state == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign host_room = (host_len < LEN_W'(MAX_NAME_LEN));
  assign cert_room = (cert_len < LEN_W'(MAX_NAME_LEN));
  assign host_we   = in_fire && (opcode == OP_HOST) && !host_closed && has_char && host_room;
  assign cert_we   = in_fire && (opcode == OP_CERT) && has_char && cert_room;
  assign cert_byte = to_lower(char_value);
  assign ovf_now   = overflow_seen || (has_char && !cert_room);

  assign nl_q   = nl_sel ? cq : hq;
  assign ci_inc = ci + LBL_W'(1);

  always_comb begin
    // one trailing nul dropped from each name
    hn_nul = hn;
    cn_nul = cn;
    if (hn != '0 && hq == CH_NUL) begin
      hn_nul = hn - LEN_W'(1);
    end
    if (cn != '0 && cq == CH_NUL) begin
      cn_nul = cn - LEN_W'(1);
    end
    // leading dot of a label is skipped
    nl_p1 = nl_p;
    nl_r1 = nl_r;
    if (nl_q == CH_DOT) begin
      nl_p1 = nl_p + LEN_W'(1);
      nl_r1 = nl_r - LEN_W'(1);
    end
  end

  dwhm_ram u_host_ram (
    .clk   (clk),
    .we    (host_we),
    .waddr (host_len[NAME_AW-1:0]),
    .wdata (char_value),
    .raddr (haddr),
    .rdata (hq)
  );

  dwhm_ram u_cert_ram (
    .clk   (clk),
    .we    (cert_we),
    .waddr (cert_len[NAME_AW-1:0]),
    .wdata (cert_byte),
    .raddr (caddr),
    .rdata (cq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      host_len      <= '0;
      cert_len      <= '0;
      overflow_seen <= 1'b0;
      host_closed   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // a result taken while the next one is handed over is replaced below
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (opcode == OP_HOST) begin
              // host beats after the host name closed are dropped
              if (!host_closed) begin
                if (has_char) begin
                  if (host_room) begin
                    host_len <= host_len + LEN_W'(1);
                  end else begin
                    overflow_seen <= 1'b1;
                  end
                end
                if (last) begin
                  host_closed <= 1'b1;
                end
              end
            end else begin
              if (has_char) begin
                if (cert_room) begin
                  cert_len <= cert_len + LEN_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              if (last) begin
                if (ovf_now) begin
                  res_match <= 1'b0;
                  res_long  <= 1'b1;
                  state     <= S_FIN;
                end else begin
                  state <= S_PRE0;
                end
              end
            end
          end
        end
        S_WAIT: begin
          // store read in flight
          state <= wait_ret;
        end
        S_PRE0: begin
          hn       <= host_len;
          cn       <= cert_len;
          hp       <= '0;
          cp       <= '0;
          res_long <= 1'b0;
          haddr    <= NAME_AW'(host_len - LEN_W'(1));
          caddr    <= NAME_AW'(cert_len - LEN_W'(1));
          wait_ret <= S_PRE1;
          state    <= S_WAIT;
        end
        S_PRE1: begin
          if (hn_nul == '0 || cn_nul == '0) begin
            // empty name matches only an empty name
            res_match <= (hn_nul == cn_nul);
            state     <= S_FIN;
          end else begin
            hn       <= hn_nul;
            cn       <= cn_nul;
            haddr    <= NAME_AW'(hn_nul - LEN_W'(1));
            caddr    <= NAME_AW'(cn_nul - LEN_W'(1));
            wait_ret <= S_PRE2;
            state    <= S_WAIT;
          end
        end
        S_PRE2: begin
          // one trailing dot dropped
          if (hq == CH_DOT) begin
            hn <= hn - LEN_W'(1);
          end
          if (cq == CH_DOT) begin
            cn <= cn - LEN_W'(1);
          end
          state <= S_EXACT;
        end
        S_EXACT: begin
          if (hn == cn) begin
            sh      <= '0;
            sc      <= '0;
            sn      <= hn;
            sk      <= '0;
            sub_ret <= S_EXACT_R;
            state   <= S_SM_START;
          end else begin
            state <= S_LBL;
          end
        end
        S_EXACT_R: begin
          if (sres) begin
            res_match <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_LBL;
          end
        end
        S_LBL: begin
          nl_sel  <= 1'b0;
          nl_p    <= hp;
          nl_r    <= hn;
          sub_ret <= S_LBL_C;
          state   <= S_NL_START;
        end
        S_LBL_C: begin
          nl_sel  <= 1'b1;
          nl_p    <= cp;
          nl_r    <= cn;
          sub_ret <= S_LBL_M;
          state   <= S_NL_START;
        end
        S_LBL_M: begin
          if (fh != fc) begin
            res_match <= 1'b0;
            state     <= S_FIN;
          end else if (!fh) begin
            res_match <= 1'b1;
            state     <= S_FIN;
          end else begin
            hi    <= '0;
            ci    <= '0;
            state <= S_LM_TOP;
          end
        end
        S_LM_TOP: begin
          fs_i    <= ci;
          sub_ret <= S_LM_BR;
          state   <= S_FS_START;
        end
        S_LM_BR: begin
          if (star == cl) begin
            // no asterisk left: rest must be equal
            if ((hl - hi) == (cl - ci)) begin
              sh      <= hs + LEN_W'(hi);
              sc      <= cs + LEN_W'(ci);
              sn      <= LEN_W'(cl - ci);
              sk      <= '0;
              sub_ret <= S_LM_FINAL;
              state   <= S_SM_START;
            end else begin
              res_match <= 1'b0;
              state     <= S_FIN;
            end
          end else if (star != ci) begin
            // literal run before the asterisk
            if ((star - ci) > (hl - hi)) begin
              res_match <= 1'b0;
              state     <= S_FIN;
            end else begin
              seg     <= star - ci;
              sh      <= hs + LEN_W'(hi);
              sc      <= cs + LEN_W'(ci);
              sn      <= LEN_W'(star - ci);
              sk      <= '0;
              sub_ret <= S_LM_LIT;
              state   <= S_SM_START;
            end
          end else if (ci_inc == cl) begin
            // trailing asterisk takes the rest of the label
            state <= S_LBL;
          end else begin
            wpos    <= ci_inc;
            fs_i    <= ci_inc;
            sub_ret <= S_LM_WILD;
            state   <= S_FS_START;
          end
        end
        S_LM_FINAL: begin
          if (sres) begin
            state <= S_LBL;
          end else begin
            res_match <= 1'b0;
            state     <= S_FIN;
          end
        end
        S_LM_LIT: begin
          if (!sres) begin
            res_match <= 1'b0;
            state     <= S_FIN;
          end else begin
            hi    <= hi + seg;
            ci    <= star;
            state <= S_LM_END;
          end
        end
        S_LM_WILD: begin
          // two asterisks in a row never match
          if (star == wpos) begin
            res_match <= 1'b0;
            state     <= S_FIN;
          end else begin
            seg   <= star - wpos;
            nxt   <= star;
            fi    <= hi;
            state <= S_FS_TRY;
          end
        end
        S_FS_TRY: begin
          // leftmost search for the segment after the asterisk
          if ((LEN_W'(fi) + LEN_W'(seg)) > LEN_W'(hl)) begin
            res_match <= 1'b0;
            state     <= S_FIN;
          end else begin
            sh      <= hs + LEN_W'(fi);
            sc      <= cs + LEN_W'(wpos);
            sn      <= LEN_W'(seg);
            sk      <= '0;
            sub_ret <= S_FS_CHK;
            state   <= S_SM_START;
          end
        end
        S_FS_CHK: begin
          if (sres) begin
            hi    <= fi + seg;
            ci    <= nxt;
            state <= S_LM_END;
          end else begin
            fi    <= fi + LBL_W'(1);
            state <= S_FS_TRY;
          end
        end
        S_LM_END: begin
          if (hi == hl && ci == cl) begin
            state <= S_LBL;
          end else begin
            state <= S_LM_TOP;
          end
        end
        S_SM_START: begin
          if (sk == sn) begin
            sres  <= 1'b1;
            state <= sub_ret;
          end else begin
            haddr    <= NAME_AW'(sh + sk);
            caddr    <= NAME_AW'(sc + sk);
            wait_ret <= S_SM_USE;
            state    <= S_WAIT;
          end
        end
        S_SM_USE: begin
          if (hq != cq) begin
            sres  <= 1'b0;
            state <= sub_ret;
          end else begin
            sk    <= sk + LEN_W'(1);
            state <= S_SM_START;
          end
        end
        S_FS_START: begin
          if (fs_i == cl) begin
            star  <= cl;
            state <= sub_ret;
          end else begin
            caddr    <= NAME_AW'(cs + LEN_W'(fs_i));
            wait_ret <= S_FS_USE;
            state    <= S_WAIT;
          end
        end
        S_FS_USE: begin
          if (cq == CH_STAR) begin
            star  <= fs_i;
            state <= sub_ret;
          end else begin
            fs_i  <= fs_i + LBL_W'(1);
            state <= S_FS_START;
          end
        end
        S_NL_START: begin
          if (nl_r == '0) begin
            nl_n   <= '0;
            nl_got <= 1'b0;
            state  <= S_NL_RET;
          end else begin
            if (nl_sel) begin
              caddr <= NAME_AW'(nl_p);
            end else begin
              haddr <= NAME_AW'(nl_p);
            end
            wait_ret <= S_NL_DOT;
            state    <= S_WAIT;
          end
        end
        S_NL_DOT: begin
          nl_p <= nl_p1;
          nl_r <= nl_r1;
          nl_s <= nl_p1;
          nl_n <= '0;
          if (nl_r1 == '0) begin
            nl_got <= 1'b0;
            state  <= S_NL_RET;
          end else begin
            if (nl_sel) begin
              caddr <= NAME_AW'(nl_p1);
            end else begin
              haddr <= NAME_AW'(nl_p1);
            end
            wait_ret <= S_NL_SCAN;
            state    <= S_WAIT;
          end
        end
        S_NL_SCAN: begin
          if (nl_q == CH_DOT) begin
            nl_got <= (nl_n != '0);
            state  <= S_NL_RET;
          end else begin
            nl_p <= nl_p + LEN_W'(1);
            nl_r <= nl_r - LEN_W'(1);
            nl_n <= nl_n + LBL_W'(1);
            // label ends at the name end or at the label length cap
            if ((nl_n + LBL_W'(1)) >= LBL_W'(MAX_LABEL_LEN) || nl_r == LEN_W'(1)) begin
              nl_got <= 1'b1;
              state  <= S_NL_RET;
            end else begin
              if (nl_sel) begin
                caddr <= NAME_AW'(nl_p + LEN_W'(1));
              end else begin
                haddr <= NAME_AW'(nl_p + LEN_W'(1));
              end
              wait_ret <= S_NL_SCAN;
              state    <= S_WAIT;
            end
          end
        end
        S_NL_RET: begin
          if (nl_sel) begin
            cp <= nl_p;
            cn <= nl_r;
            cs <= nl_s;
            cl <= nl_n;
            fc <= nl_got;
          end else begin
            hp <= nl_p;
            hn <= nl_r;
            hs <= nl_s;
            hl <= nl_n;
            fh <= nl_got;
          end
          state <= sub_ret;
        end
        S_FIN: begin
          // hand the result over once the output register is free
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            match         <= res_match;
            too_long      <= res_long;
            host_len      <= '0;
            cert_len      <= '0;
            overflow_seen <= 1'b0;
            host_closed   <= 1'b0;
            state         <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/dwhm_checker.sv
`timescale 1ns / 1ps

module dwhm_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            opcode,
  input logic            has_char,
  input dwhm_pkg::byte_t char_value,
  input logic            last,
  input logic            out_valid,
  input logic            out_ready,
  input logic            match,
  input logic            too_long
);
  import dwhm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match) && $stable(too_long))
    else $error("result changed while stalled");

  // overflow result never claims a match
  a_long_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(match && too_long))
    else $error("too_long result with match set");

  // the closing certificate beat starts the compare, input is held off
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_CERT) && last |=> !in_ready)
    else $error("input taken right after closing beat");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind dns_wildcard_host_match_top dwhm_checker u_dwhm_checker (.*);

>>> sim/dns_wildcard_host_match_top_test.sv
`timescale 1ns / 1ps

module dns_wildcard_host_match_top_test;
  import dwhm_pkg::*;

  // scoreboard: a local copy of both name stores and the predicted match results
  class host_match_board;
    byte_t host_mem[MAX_NAME_LEN];
    byte_t cert_mem[MAX_NAME_LEN];
    int    host_len;
    int    cert_len;
    bit    overflow;
    bit    host_done;
    bit    pending_match[$];
    bit    pending_long[$];
    int    errors;
    int    results;
    int    match_hits;
    int    longs;

    function new();
      host_len = 0;
      cert_len = 0;
      overflow = 0;
      host_done = 0;
      errors = 0;
      results = 0;
      match_hits = 0;
      longs = 0;
    endfunction

    function bit same_bytes(int hb, int cb, int n);
      for (int i = 0; i < n; i++) begin
        if (host_mem[hb + i] != cert_mem[cb + i]) return 0;
      end
      return 1;
    endfunction

    function int find_star(int from, int to);
      for (int i = from; i < to; i++) begin
        if (cert_mem[i] == CH_STAR) return i;
      end
      return to;
    endfunction

    function bit label_match(int hb, int hl, int cb, int cl);
      int hi;
      int ci;
      int star;
      int seg;
      int w;
      int nxt;
      int found;
      hi = 0;
      ci = 0;
      forever begin
        star = find_star(cb + ci, cb + cl) - cb;
        if (star == cl) return (hl - hi == cl - ci) && same_bytes(hb + hi, cb + ci, cl - ci);
        if (star != ci) begin
          seg = star - ci;
          if (seg > hl - hi || !same_bytes(hb + hi, cb + ci, seg)) return 0;
          hi += seg;
          ci = star;
        end else begin
          w = ci + 1;
          if (w == cl) return 1;
          nxt = find_star(cb + w, cb + cl) - cb;
          seg = nxt - w;
          if (seg == 0) return 0;
          found = -1;
          for (int i = hi; i + seg <= hl; i++) begin
            if (same_bytes(hb + i, cb + w, seg)) begin
              found = i;
              break;
            end
          end
          if (found < 0) return 0;
          hi = found + seg;
          ci = nxt;
        end
        if (hi == hl && ci == cl) return 1;
      end
    endfunction

    function byte_t rd(bit is_cert, int idx);
      return is_cert ? cert_mem[idx] : host_mem[idx];
    endfunction

    // split off the next label; returns 1 when it holds bytes
    function bit next_label(bit is_cert, inout int pos, inout int rem,
                            output int start, output int len);
      int n;
      n = 0;
      start = 0;
      if (rem != 0) begin
        if (rd(is_cert, pos) == CH_DOT) begin
          pos++;
          rem--;
        end
        if (rem != 0) begin
          start = pos;
          do begin
            if (rd(is_cert, pos) == CH_DOT) break;
            pos++;
            rem--;
            n++;
            if (n >= MAX_LABEL_LEN) break;
          end while (rem != 0);
        end
      end
      len = n;
      return n != 0;
    endfunction

    function bit names_match();
      int hn;
      int cn;
      int hp;
      int cp;
      int hs;
      int hl;
      int cs;
      int cl;
      bit fh;
      bit fc;
      hn = host_len;
      cn = cert_len;
      hp = 0;
      cp = 0;
      if (hn != 0 && host_mem[hn - 1] == CH_NUL) hn--;
      if (cn != 0 && cert_mem[cn - 1] == CH_NUL) cn--;
      if (hn == 0 || cn == 0) return hn == cn;
      if (host_mem[hn - 1] == CH_DOT) hn--;
      if (cert_mem[cn - 1] == CH_DOT) cn--;
      if (hn == cn && same_bytes(0, 0, hn)) return 1;
      forever begin
        fh = next_label(0, hp, hn, hs, hl);
        fc = next_label(1, cp, cn, cs, cl);
        if (fh != fc) return 0;
        if (!fh) return 1;
        if (!label_match(hs, hl, cs, cl)) return 0;
      end
    endfunction

    function void note_beat(logic op, logic has, byte_t ch, logic lst);
      if (op == OP_HOST) begin
        if (host_done) return;
        if (has) begin
          if (host_len < MAX_NAME_LEN) host_mem[host_len++] = ch;
          else overflow = 1;
        end
        if (lst) host_done = 1;
        return;
      end
      if (has) begin
        if (ch >= CH_UP_A && ch <= CH_UP_Z) ch = ch + CASE_OFS;
        if (cert_len < MAX_NAME_LEN) cert_mem[cert_len++] = ch;
        else overflow = 1;
      end
      if (!lst) return;
      if (overflow) begin
        pending_match.push_back(0);
        pending_long.push_back(1);
      end else begin
        pending_match.push_back(names_match());
        pending_long.push_back(0);
      end
      host_len = 0;
      cert_len = 0;
      overflow = 0;
      host_done = 0;
    endfunction

    function void check_result(logic m, logic tl);
      bit em;
      bit el;
      if (pending_match.size() == 0) begin
        $error("result beat with no pending compare: match %0d too_long %0d", m, tl);
        errors++;
        return;
      end
      em = pending_match.pop_front();
      el = pending_long.pop_front();
      results++;
      if (em) match_hits++;
      if (el) longs++;
      if (m !== em) begin
        $error("match: expected %0d, actual %0d", em, m);
        errors++;
      end
      if (tl !== el) begin
        $error("too_long: expected %0d, actual %0d", el, tl);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int ITEM_TARGET    = 650;
  localparam int QUIET_FROM     = 560;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  logic  opcode;
  logic  has_char;
  byte_t char_value;
  logic  last;
  logic  out_valid;
  logic  out_ready;
  logic  match;
  logic  too_long;

  host_match_board board;
  int  beats_in;
  int  stall_cycles;
  bit  quiet;

  dns_wildcard_host_match_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .has_char   (has_char),
    .char_value (char_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .match      (match),
    .too_long   (too_long)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // watchdog: ends the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: ready drops in random bursts until the quiet tail
  initial begin : result_sink
    int hold;
    out_ready = 0;
    hold = 0;
    @(negedge clk);
    forever begin
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_result(match, too_long);
      @(negedge clk);
    end
  end

  // one input beat; may open with an idle burst, returns at the negedge after acceptance
  // with valid still high; the next beat or the drain wait takes it down
  task automatic send_beat(logic op, logic has, byte_t ch, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        in_valid <= 0;
        @(negedge clk);
      end
    end
    in_valid   <= 1;
    opcode     <= op;
    has_char   <= has;
    char_value <= ch;
    last       <= lst;
    do @(posedge clk); while (!in_ready);
    board.note_beat(op, has, ch, lst);
    beats_in++;
    @(negedge clk);
  endtask

  // a whole name; an empty name is a single no-byte beat that closes it
  task automatic send_name(logic op, byte_t nm[$], bit noisy);
    if (nm.size() == 0) begin
      send_beat(op, 0, byte_t'($urandom_range(0, 255)), 1);
      return;
    end
    for (int i = 0; i < nm.size(); i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_beat(op, 0, byte_t'($urandom_range(0, 255)), 0);
      end
      send_beat(op, 1, nm[i], (i == nm.size() - 1));
    end
  endtask

  function automatic byte_t pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return byte_t'("a" + $urandom_range(0, 2));
    if (r < 17) return byte_t'("A" + $urandom_range(0, 2));
    if (r < 18) return CH_STAR;
    return byte_t'($urandom_range(0, 255));
  endfunction

  // dotted name of short labels from a tiny alphabet, so that names often agree
  function automatic void build_name(ref byte_t nm[$], input int max_lbl);
    int labels;
    int ln;
    nm.delete();
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      if (l != 0) nm.push_back(CH_DOT);
      ln = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, max_lbl);
      for (int i = 0; i < ln; i++) nm.push_back(pick_char());
    end
  endfunction

  // certificate name from the host name: case flips and runs turned into wildcards
  function automatic void derive_cert(byte_t hn[$], ref byte_t cn[$]);
    int i;
    int run;
    cn.delete();
    i = 0;
    while (i < hn.size()) begin
      if (hn[i] != CH_DOT && $urandom_range(0, 5) == 0) begin
        run = $urandom_range(0, 3);
        cn.push_back(CH_STAR);
        if ($urandom_range(0, 9) == 0) cn.push_back(CH_STAR);
        while (run > 0 && i < hn.size() && hn[i] != CH_DOT) begin
          i++;
          run--;
        end
      end else begin
        if (hn[i] >= "a" && hn[i] <= "z" && $urandom_range(0, 3) == 0) cn.push_back(hn[i] - CASE_OFS);
        else cn.push_back(hn[i]);
        i++;
      end
    end
  endfunction

  function automatic void add_tail(ref byte_t nm[$]);
    if ($urandom_range(0, 4) == 0) nm.push_back(CH_DOT);
    if ($urandom_range(0, 9) == 0) nm.push_back(CH_NUL);
  endfunction

  // full host/cert pair of random content; flavor picks the kind
  task automatic send_random_pair();
    byte_t hn[$];
    byte_t cn[$];
    int    kind;
    int    extra;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      // oversize host name
      hn.delete();
      repeat ($urandom_range(MAX_NAME_LEN + 1, MAX_NAME_LEN + 4)) hn.push_back("a");
      build_name(cn, 4);
    end else if (kind < 5) begin
      // one label near or over the label limit on both sides
      hn.delete();
      repeat ($urandom_range(MAX_LABEL_LEN - 2, MAX_LABEL_LEN + 6)) hn.push_back("b");
      hn.push_back(CH_DOT);
      hn.push_back("c");
      cn = hn;
      if ($urandom_range(0, 1)) cn[$urandom_range(0, MAX_LABEL_LEN - 3)] = CH_STAR;
    end else if (kind < 10) begin
      // empty names on one or both sides
      if ($urandom_range(0, 1)) build_name(hn, 3);
      else hn.delete();
      if ($urandom_range(0, 1)) build_name(cn, 3);
      else cn.delete();
    end else if (kind < 16) begin
      // noise: random opcodes and bytes, including certificate bytes before the host closes
      repeat ($urandom_range(1, 8)) begin
        send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      return;
    end else begin
      build_name(hn, 5);
      if ($urandom_range(0, 3) == 0) build_name(cn, 5);
      else derive_cert(hn, cn);
    end
    add_tail(hn);
    add_tail(cn);
    send_name(OP_HOST, hn, 1);
    // host beats after the host name closed are dropped by the block
    if ($urandom_range(0, 9) == 0) begin
      extra = $urandom_range(1, 3);
      repeat (extra) begin
        send_beat(OP_HOST, 1, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    send_name(OP_CERT, cn, 1);
  endtask

  task automatic send_pair_str(string h, string c);
    byte_t hn[$];
    byte_t cn[$];
    for (int i = 0; i < h.len(); i++) hn.push_back(h[i]);
    for (int i = 0; i < c.len(); i++) cn.push_back(c[i]);
    send_name(OP_HOST, hn, 0);
    send_name(OP_CERT, cn, 0);
  endtask

  // called at a negedge right after a beat went in; valid drops first
  task automatic wait_drained();
    in_valid <= 0;
    while (board.pending_match.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int pairs;
    board        = new();
    beats_in     = 0;
    stall_cycles = 0;
    quiet        = 0;
    rst          = 1;
    in_valid     = 0;
    opcode       = OP_HOST;
    has_char     = 0;
    char_value   = '0;
    last         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: empty names, case folding, trailing nul and dot, wildcards
    send_pair_str("", "");
    send_pair_str("a", "");
    send_pair_str("ab.c", "AB.C.");
    send_pair_str("a.b", "*.b");
    send_pair_str("ab", "a**b");
    send_pair_str("a..b", "a..c");
    send_beat(OP_HOST, 1, 8'hff, 0);
    send_beat(OP_HOST, 1, CH_NUL, 1);
    send_beat(OP_CERT, 1, 8'hff, 1);

    // pressure point: hold the sender until every result is back
    wait_drained();
    pairs = 0;
    while (beats_in < ITEM_TARGET) begin
      if (beats_in >= QUIET_FROM) quiet = 1;
      send_random_pair();
      pairs++;
      if (pairs == 20) wait_drained();
    end

    wait_drained();
    repeat (100) @(negedge clk);
    $display("%0d input beats over %0d random pairs; %0d results, %0d matches, %0d oversize",
             beats_in, pairs, board.results, board.match_hits, board.longs);
    if (board.errors == 0 && board.pending_match.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dwhm_pkg.sv
hw/rtl/dwhm_ram.sv
hw/rtl/dns_wildcard_host_match_top.sv
hw/rtl/dwhm_checker.sv
sim/dns_wildcard_host_match_top_test.sv
